// ===== design/d8fd_pkg.sv =====
// ---------------------------------------------------------------------------
// D8 flow direction package
// Types and constants that the slope unit, the cells and the top level share.
// ---------------------------------------------------------------------------
package d8fd_pkg;

   // Border codes carried on the request channel.
   localparam logic [2:0] BORDER_INTERIOR = 3'd0;
   localparam logic [2:0] BORDER_TOP      = 3'd1;
   localparam logic [2:0] BORDER_BOTTOM   = 3'd2;
   localparam logic [2:0] BORDER_LEFT     = 3'd3;
   localparam logic [2:0] BORDER_RIGHT    = 3'd4;

   // Fixed direction codes for cells on the map border, and the pit code.
   localparam logic signed [8:0] TOP_CODE    = 9'sd128;
   localparam logic signed [8:0] BOTTOM_CODE = 9'sd8;
   localparam logic signed [8:0] LEFT_CODE   = 9'sd32;
   localparam logic signed [8:0] RIGHT_CODE  = 9'sd2;
   localparam logic signed [8:0] PIT_CODE    = -9'sd256;

   localparam int NUM_NEIGHBORS = 8;

   // Neighbor visiting order is NW, N, NE, W, E, SW, S, SE.
   localparam logic [7:0] DIR_CODE [NUM_NEIGHBORS] = '{
      8'd64, 8'd128, 8'd1, 8'd32, 8'd2, 8'd16, 8'd8, 8'd4
   };

   // Bit n is set when neighbor n lies on a diagonal.
   localparam logic [NUM_NEIGHBORS-1:0] DIAG_MASK = 8'b1010_0101;

   // Q16 reciprocal of sqrt(2), rounded to nearest.
   localparam logic signed [16:0] DIAG_Q16 = 17'sd46341;

   // Progress of the steepest-descent search.
   typedef enum logic [1:0] {
      KIND_NONE  = 2'd0,
      KIND_SLOPE = 2'd1,
      KIND_NULL  = 2'd2
   } kind_type;

   // Window control and the running direction that travel down the cell row.
   typedef struct packed {
      logic [8:0]        mask;
      logic [2:0]        border;
      kind_type          kind;
      logic signed [8:0] dir;
   } ctl_type;

endpackage

// ===== design/d8fd_if.sv =====
// ---------------------------------------------------------------------------
// D8 flow direction channels
// Valid/ready request and response channels with their payload fields.
// ---------------------------------------------------------------------------
interface d8fd_req_if #(
   parameter int ELEV_WIDTH = 32
);
   logic                         valid;
   logic                         ready;
   logic signed [ELEV_WIDTH-1:0] center_elev;
   logic signed [ELEV_WIDTH-1:0] northwest_elev;
   logic signed [ELEV_WIDTH-1:0] north_elev;
   logic signed [ELEV_WIDTH-1:0] northeast_elev;
   logic signed [ELEV_WIDTH-1:0] west_elev;
   logic signed [ELEV_WIDTH-1:0] east_elev;
   logic signed [ELEV_WIDTH-1:0] southwest_elev;
   logic signed [ELEV_WIDTH-1:0] south_elev;
   logic signed [ELEV_WIDTH-1:0] southeast_elev;
   logic [8:0]                   null_mask;
   logic [2:0]                   border;

   modport source (
      output valid, center_elev, northwest_elev, north_elev, northeast_elev,
             west_elev, east_elev, southwest_elev, south_elev, southeast_elev,
             null_mask, border,
      input  ready
   );

   modport sink (
      input  valid, center_elev, northwest_elev, north_elev, northeast_elev,
             west_elev, east_elev, southwest_elev, south_elev, southeast_elev,
             null_mask, border,
      output ready
   );
endinterface

interface d8fd_rsp_if;
   logic              valid;
   logic              ready;
   logic signed [8:0] direction;
   logic              direction_null;

   modport source (
      output valid, direction, direction_null,
      input  ready
   );

   modport sink (
      input  valid, direction, direction_null,
      output ready
   );
endinterface

// ===== design/d8fd_slope.sv =====
// ---------------------------------------------------------------------------
// D8 flow direction slope unit
// Exact Q16 slope from the centre to one neighbor, diagonal drops scaled.
// ---------------------------------------------------------------------------
module d8fd_slope import d8fd_pkg::*; #(
   parameter int   ELEV_WIDTH = 32,
   parameter logic DIAG       = 1'b0
) (
   input  logic signed [ELEV_WIDTH-1:0]  center,
   input  logic signed [ELEV_WIDTH-1:0]  neighbor,
   output logic signed [ELEV_WIDTH+16:0] slope
);

   logic signed [ELEV_WIDTH:0] drop;

   // The drop is exact in one extra bit.
   assign drop = $signed({center[ELEV_WIDTH-1], center})
               - $signed({neighbor[ELEV_WIDTH-1], neighbor});

   generate
      if (DIAG) begin : g_diag
         // The product of the drop and the Q16 factor fits the slope exactly.
         assign slope = drop * DIAG_Q16;
      end else begin : g_ortho
         assign slope = {drop, 16'd0};
      end
   endgenerate

endmodule

// ===== design/d8fd_cell.sv =====
// ---------------------------------------------------------------------------
// D8 flow direction cell
// Folds one neighbor into the running steepest descent, or ends the search at
// a null neighbor; all but the last cell prepare the next slope for the following cell.
// ---------------------------------------------------------------------------
module d8fd_cell import d8fd_pkg::*; #(
   parameter int ELEV_WIDTH = 32,
   parameter int INDEX      = 0
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               up_valid,
   output logic                               up_ready,
   input  logic [8:0][ELEV_WIDTH-1:0]         up_elev,
   input  ctl_type                            up_ctl,
   input  logic signed [ELEV_WIDTH+16:0]      up_best,
   input  logic signed [ELEV_WIDTH+16:0]      up_slope,
   output logic                               dn_valid,
   input  logic                               dn_ready,
   output logic [8:0][ELEV_WIDTH-1:0]         dn_elev,
   output ctl_type                            dn_ctl,
   output logic signed [ELEV_WIDTH+16:0]      dn_best,
   output logic signed [ELEV_WIDTH+16:0]      dn_slope
);

   localparam int NEXT = (INDEX + 1) % NUM_NEIGHBORS;

   logic                          valid_ff;
   logic [8:0][ELEV_WIDTH-1:0]    elev_ff;
   ctl_type                       ctl_ff;
   ctl_type                       ctl_in;
   logic signed [ELEV_WIDTH+16:0] best_ff;
   logic signed [ELEV_WIDTH+16:0] best_in;
   logic                          load;

   assign up_ready = !valid_ff || dn_ready;
   assign load     = up_valid && up_ready;

   always_comb begin
      ctl_in  = up_ctl;
      best_in = up_best;
      priority if (up_ctl.mask[INDEX+1]) begin
         ctl_in.kind = KIND_NULL;
         ctl_in.dir  = $signed({1'b0, DIR_CODE[INDEX]});
      end else if (up_ctl.kind == KIND_NONE) begin
         ctl_in.kind = KIND_SLOPE;
         ctl_in.dir  = $signed({1'b0, DIR_CODE[INDEX]});
         best_in     = up_slope;
      end else if (up_ctl.kind == KIND_SLOPE) begin
         if (up_slope == up_best) begin
            ctl_in.dir = up_ctl.dir + $signed({1'b0, DIR_CODE[INDEX]});
         end else if (up_slope > up_best) begin
            ctl_in.dir = $signed({1'b0, DIR_CODE[INDEX]});
            best_in    = up_slope;
         end
      end else begin
         ctl_in = up_ctl;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         elev_ff <= up_elev;
         ctl_ff  <= ctl_in;
         best_ff <= best_in;
      end
   end

   generate
      if (INDEX < NUM_NEIGHBORS - 1) begin : g_next
         logic signed [ELEV_WIDTH+16:0] slope_ff;
         logic signed [ELEV_WIDTH+16:0] slope_in;

         d8fd_slope #(
            .ELEV_WIDTH (ELEV_WIDTH),
            .DIAG       (DIAG_MASK[NEXT])
         ) u_slope (
            .center   (up_elev[0]),
            .neighbor (up_elev[NEXT+1]),
            .slope    (slope_in)
         );

         always_ff @(posedge clock) begin
            if (load) begin
               slope_ff <= slope_in;
            end
         end

         assign dn_slope = slope_ff;
      end else begin : g_last
         assign dn_slope = '0;
      end
   endgenerate

   assign dn_valid = valid_ff;
   assign dn_elev  = elev_ff;
   assign dn_ctl   = ctl_ff;
   assign dn_best  = best_ff;

endmodule

// ===== design/d8_flow_direction.sv =====
// ---------------------------------------------------------------------------
// D8 flow direction
// Streams 3x3 elevation windows in and gives one D8 direction code per window.
// ---------------------------------------------------------------------------
// Each request beat carries one window: the centre elevation, its eight
// neighbors, a nine-bit null mask (bit 0 the centre) and a border code. Each
// response beat carries the summed D8 code and a flag that marks a null centre.
// A window becomes one response beat, in order.
//
// The window enters an input register where the slope of the first neighbor is
// formed, then walks down a row of eight cells, one per neighbor. Each cell
// folds its neighbor into the running steepest drop, and each but the last forms
// the slope of the next neighbor; a final register applies the border, flat and
// pit rules. A new window can be accepted in every cycle while the receiver takes
// responses, and the registers along the way hold up to ten windows.
// Each stage has its own valid bit and advances whenever the stage after it is
// empty or moving, so bubbles close up when the receiver stalls; the request
// side drops ready only once every stage is full. Synchronous reset empties
// all stages and no response is pending afterwards.
// ---------------------------------------------------------------------------
module d8_flow_direction import d8fd_pkg::*; #(
   parameter int ELEV_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   d8fd_req_if.sink    req,
   d8fd_rsp_if.source  rsp
);

   localparam int SLOPE_WIDTH = ELEV_WIDTH + 17;

   // Elevations are packed with the centre at index 0 and neighbor n at n+1.
   logic [8:0][ELEV_WIDTH-1:0] req_elev;

   assign req_elev = {req.southeast_elev, req.south_elev, req.southwest_elev,
                      req.east_elev, req.west_elev, req.northeast_elev,
                      req.north_elev, req.northwest_elev, req.center_elev};

   // Input register: captures the window and the slope of the first neighbor.
   logic                          in_valid_ff;
   logic [8:0][ELEV_WIDTH-1:0]    in_elev_ff;
   ctl_type                       in_ctl_ff;
   ctl_type                       in_ctl_in;
   logic signed [SLOPE_WIDTH-1:0] in_slope_ff;
   logic signed [SLOPE_WIDTH-1:0] in_slope_in;

   // Hand-off signals along the cell row; entry k feeds cell k. The last
   // slope entry only carries the constant that the last cell puts out.
   logic                                          row_valid [NUM_NEIGHBORS+1];
   logic                                          row_ready [NUM_NEIGHBORS+1];
   logic [NUM_NEIGHBORS:0][8:0][ELEV_WIDTH-1:0]  row_elev;
   ctl_type                                       row_ctl   [NUM_NEIGHBORS+1];
   logic signed [SLOPE_WIDTH-1:0]                 row_best  [NUM_NEIGHBORS+1];
   logic signed [SLOPE_WIDTH-1:0]                 row_slope [NUM_NEIGHBORS+1];

   assign req.ready = !in_valid_ff || row_ready[0];

   d8fd_slope #(
      .ELEV_WIDTH (ELEV_WIDTH),
      .DIAG       (DIAG_MASK[0])
   ) u_first_slope (
      .center   (req.center_elev),
      .neighbor (req.northwest_elev),
      .slope    (in_slope_in)
   );

   always_comb begin
      in_ctl_in.mask   = req.null_mask;
      in_ctl_in.border = req.border;
      in_ctl_in.kind   = KIND_NONE;
      in_ctl_in.dir    = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req.ready) begin
         in_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         in_elev_ff  <= req_elev;
         in_ctl_ff   <= in_ctl_in;
         in_slope_ff <= in_slope_in;
      end
   end

   assign row_valid[0] = in_valid_ff;
   assign row_elev[0]  = in_elev_ff;
   assign row_ctl[0]   = in_ctl_ff;
   assign row_best[0]  = '0;
   assign row_slope[0] = in_slope_ff;

   // One cell per neighbor, visited NW, N, NE, W, E, SW, S, SE.
   genvar k;
   generate
      for (k = 0; k < NUM_NEIGHBORS; k++) begin : g_cell
         d8fd_cell #(
            .ELEV_WIDTH (ELEV_WIDTH),
            .INDEX      (k)
         ) u_cell (
            .clock    (clock),
            .reset    (reset),
            .up_valid (row_valid[k]),
            .up_ready (row_ready[k]),
            .up_elev  (row_elev[k]),
            .up_ctl   (row_ctl[k]),
            .up_best  (row_best[k]),
            .up_slope (row_slope[k]),
            .dn_valid (row_valid[k+1]),
            .dn_ready (row_ready[k+1]),
            .dn_elev  (row_elev[k+1]),
            .dn_ctl   (row_ctl[k+1]),
            .dn_best  (row_best[k+1]),
            .dn_slope (row_slope[k+1])
         );
      end
   endgenerate

   // Output register: border codes, null centre, flat and pit rules.
   ctl_type                       last_ctl;
   logic signed [SLOPE_WIDTH-1:0] last_best;
   logic                          rsp_valid_ff;
   logic signed [8:0]             rsp_dir_ff;
   logic signed [8:0]             rsp_dir_in;
   logic                          rsp_null_ff;
   logic                          rsp_null_in;

   assign last_ctl  = row_ctl[NUM_NEIGHBORS];
   assign last_best = row_best[NUM_NEIGHBORS];

   // The row's elevations are not needed past the last cell.
   assign row_ready[NUM_NEIGHBORS] = !rsp_valid_ff || rsp.ready;

   always_comb begin
      rsp_null_in = 1'b0;
      rsp_dir_in  = last_ctl.dir;
      if (last_ctl.mask[0]) begin
         rsp_null_in = 1'b1;
         rsp_dir_in  = '0;
      end else begin
         unique case (last_ctl.border)
            BORDER_TOP:    rsp_dir_in = TOP_CODE;
            BORDER_BOTTOM: rsp_dir_in = BOTTOM_CODE;
            BORDER_LEFT:   rsp_dir_in = LEFT_CODE;
            BORDER_RIGHT:  rsp_dir_in = RIGHT_CODE;
            default: begin
               // Interior, and border codes that mean nothing, use the search.
               if (last_ctl.kind == KIND_SLOPE) begin
                  if (last_best == '0) begin
                     rsp_dir_in = -last_ctl.dir;
                  end else if (last_best < 0) begin
                     rsp_dir_in = PIT_CODE;
                  end
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (row_ready[NUM_NEIGHBORS]) begin
         rsp_valid_ff <= row_valid[NUM_NEIGHBORS];
      end
   end

   always_ff @(posedge clock) begin
      if (row_valid[NUM_NEIGHBORS] && row_ready[NUM_NEIGHBORS]) begin
         rsp_dir_ff  <= rsp_dir_in;
         rsp_null_ff <= rsp_null_in;
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.direction      = rsp_dir_ff;
   assign rsp.direction_null = rsp_null_ff;

endmodule
